// ----- rtl/npd_pkg.sv -----
// Shared types, constants and the multiply schedule for the nearest polyline distance block.
package npd_pkg;

    localparam int COORD_BITS = 30;
    localparam int IDX_BITS   = 10;
    localparam int DIST_BITS  = 31;
    localparam int SQ_BITS    = 62;
    localparam int RANK_BITS  = 3;
    localparam int KCNT_BITS  = 4;
    localparam int MAX_K      = 8;
    localparam int QDEPTH     = 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_OPEN  = 2'd1;
    localparam logic [1:0] KIND_NEXT  = 2'd2;
    localparam logic [1:0] KIND_SEG   = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic       last_vtx;
        coord_t     x;
        coord_t     y;
        coord_t     z;
    } item_t;

    localparam logic [1:0] MODE_NEAREST = 2'd0;
    localparam logic [1:0] MODE_KNN     = 2'd1;
    localparam logic [1:0] MODE_ALL     = 2'd2;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_K    = 1'b1;

    localparam logic [3:0] SRC_AB0 = 4'd0;
    localparam logic [3:0] SRC_AB1 = 4'd1;
    localparam logic [3:0] SRC_AB2 = 4'd2;
    localparam logic [3:0] SRC_AP0 = 4'd3;
    localparam logic [3:0] SRC_AP1 = 4'd4;
    localparam logic [3:0] SRC_AP2 = 4'd5;
    localparam logic [3:0] SRC_BP0 = 4'd6;
    localparam logic [3:0] SRC_BP1 = 4'd7;
    localparam logic [3:0] SRC_BP2 = 4'd8;
    localparam logic [3:0] SRC_CLO = 4'd9;
    localparam logic [3:0] SRC_CHI = 4'd10;

    localparam logic [3:0] DST_LEN   = 4'd0;
    localparam logic [3:0] DST_DOT1  = 4'd1;
    localparam logic [3:0] DST_DOT2  = 4'd2;
    localparam logic [3:0] DST_NAP   = 4'd3;
    localparam logic [3:0] DST_NBP   = 4'd4;
    localparam logic [3:0] DST_T1    = 4'd5;
    localparam logic [3:0] DST_CMAG  = 4'd6;
    localparam logic [3:0] DST_NUM0  = 4'd7;
    localparam logic [3:0] DST_NUM32 = 4'd8;
    localparam logic [3:0] DST_NUM62 = 4'd9;

    localparam logic [4:0] STEP_ENDPT = 5'd14;
    localparam logic [4:0] STEP_LAST  = 5'd29;

    typedef struct packed {
        logic [3:0] src_a;
        logic [3:0] src_b;
        logic [3:0] dst;
    } mul_op_t;

    // Schedule of the shared multiplier: norms and dots first, then cross terms.
    function automatic mul_op_t mul_op(input logic [4:0] step);
        mul_op_t r;
        case (step)
            5'd0:  r = '{SRC_AB0, SRC_AB0, DST_LEN};
            5'd1:  r = '{SRC_AB1, SRC_AB1, DST_LEN};
            5'd2:  r = '{SRC_AB2, SRC_AB2, DST_LEN};
            5'd3:  r = '{SRC_AB0, SRC_AP0, DST_DOT1};
            5'd4:  r = '{SRC_AB1, SRC_AP1, DST_DOT1};
            5'd5:  r = '{SRC_AB2, SRC_AP2, DST_DOT1};
            5'd6:  r = '{SRC_AB0, SRC_BP0, DST_DOT2};
            5'd7:  r = '{SRC_AB1, SRC_BP1, DST_DOT2};
            5'd8:  r = '{SRC_AB2, SRC_BP2, DST_DOT2};
            5'd9:  r = '{SRC_AP0, SRC_AP0, DST_NAP};
            5'd10: r = '{SRC_AP1, SRC_AP1, DST_NAP};
            5'd11: r = '{SRC_AP2, SRC_AP2, DST_NAP};
            5'd12: r = '{SRC_BP0, SRC_BP0, DST_NBP};
            5'd13: r = '{SRC_BP1, SRC_BP1, DST_NBP};
            5'd14: r = '{SRC_BP2, SRC_BP2, DST_NBP};
            5'd15: r = '{SRC_AB1, SRC_AP2, DST_T1};
            5'd16: r = '{SRC_AB2, SRC_AP1, DST_CMAG};
            5'd17: r = '{SRC_CLO, SRC_CLO, DST_NUM0};
            5'd18: r = '{SRC_CHI, SRC_CLO, DST_NUM32};
            5'd19: r = '{SRC_CHI, SRC_CHI, DST_NUM62};
            5'd20: r = '{SRC_AB2, SRC_AP0, DST_T1};
            5'd21: r = '{SRC_AB0, SRC_AP2, DST_CMAG};
            5'd22: r = '{SRC_CLO, SRC_CLO, DST_NUM0};
            5'd23: r = '{SRC_CHI, SRC_CLO, DST_NUM32};
            5'd24: r = '{SRC_CHI, SRC_CHI, DST_NUM62};
            5'd25: r = '{SRC_AB0, SRC_AP1, DST_T1};
            5'd26: r = '{SRC_AB1, SRC_AP0, DST_CMAG};
            5'd27: r = '{SRC_CLO, SRC_CLO, DST_NUM0};
            5'd28: r = '{SRC_CHI, SRC_CLO, DST_NUM32};
            5'd29: r = '{SRC_CHI, SRC_CHI, DST_NUM62};
            default: r = '{SRC_AB0, SRC_AB0, DST_LEN};
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/npd_front.sv -----
// Front end: takes requests and classifies them for the back end.
module npd_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  logic           cmd,
    input  npd_pkg::coord_t coord_x,
    input  npd_pkg::coord_t coord_y,
    input  npd_pkg::coord_t coord_z,
    input  logic           starts_polyline,
    input  logic           final_vertex,
    input  logic           q_space,
    output logic           push,
    output npd_pkg::item_t push_item
);
    import npd_pkg::*;

    logic open_reg;
    logic open_next;

    assign item_ready = q_space;
    assign push       = item_valid && q_space;

    always_comb
    begin
        push_item.x        = coord_x;
        push_item.y        = coord_y;
        push_item.z        = coord_z;
        push_item.last_vtx = final_vertex;
        if (!cmd)
            push_item.kind = KIND_QUERY;
        else if (!open_reg)
            push_item.kind = KIND_OPEN;
        else if (starts_polyline)
            push_item.kind = KIND_NEXT;
        else
            push_item.kind = KIND_SEG;
        open_next = cmd && !final_vertex;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_reg <= 1'b0;
        else if (push)
            open_reg <= open_next;
    end

endmodule

// ----- rtl/npd_queue.sv -----
// Small FIFO between the front and back ends.
module npd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  npd_pkg::item_t push_item,
    output logic           space,
    input  logic           pop,
    output logic           pop_valid,
    output npd_pkg::item_t pop_item
);
    import npd_pkg::*;

    localparam int PTR_BITS = $clog2(QDEPTH);

    item_t                 mem_reg [QDEPTH];
    logic [PTR_BITS-1:0]   wr_reg;
    logic [PTR_BITS-1:0]   rd_reg;
    logic [PTR_BITS:0]     fill_reg;

    assign space     = fill_reg != (PTR_BITS + 1)'(QDEPTH);
    assign pop_valid = fill_reg != '0;
    assign pop_item  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

// ----- rtl/npd_back.sv -----
// Back end: segment distance sequencer, divider, square root, ranking and result register.
module npd_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  npd_pkg::item_t                 q_item,
    output logic                           q_pop,
    input  logic [1:0]                     mode,
    input  logic [npd_pkg::KCNT_BITS-1:0]  k_nearest,
    output logic                           res_valid,
    input  logic                           res_ready,
    output logic [npd_pkg::IDX_BITS-1:0]   res_index,
    output logic [npd_pkg::DIST_BITS-1:0]  res_dist,
    output logic [npd_pkg::RANK_BITS-1:0]  res_rank,
    output logic                           res_found,
    output logic                           res_last
);
    import npd_pkg::*;

    localparam logic [SQ_BITS-1:0] ONES62 = {SQ_BITS{1'b1}};

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_SQRT  = 3'd3;
    localparam logic [2:0] ST_CLOSE = 3'd4;
    localparam logic [2:0] ST_FINAL = 3'd5;
    localparam logic [2:0] ST_LIST  = 3'd6;

    logic [2:0]              state_reg;
    item_t                   it_reg;
    coord_t                  qp_reg [3];
    coord_t                  prev_reg [3];
    logic signed [COORD_BITS:0] ab_reg [3];
    logic signed [COORD_BITS:0] ap_reg [3];
    logic signed [COORD_BITS:0] bp_reg [3];
    logic [IDX_BITS-1:0]     cur_reg;
    logic [SQ_BITS-1:0]      min_reg;
    logic                    has_reg;
    logic [DIST_BITS-1:0]    bd_reg [MAX_K];
    logic [IDX_BITS-1:0]     bi_reg [MAX_K];
    logic [KCNT_BITS-1:0]    count_reg;

    logic [4:0]              step_reg;
    logic                    phase_reg;
    logic signed [63:0]      mul_reg;
    logic [63:0]             len2_reg;
    logic signed [63:0]      dot1_reg;
    logic signed [63:0]      dot2_reg;
    logic [63:0]             nap_reg;
    logic [63:0]             nbp_reg;
    logic signed [63:0]      t1_reg;
    logic [SQ_BITS-1:0]      c_reg;
    logic [127:0]            num_reg;

    logic [SQ_BITS-1:0]      rem_reg;
    logic [SQ_BITS-1:0]      nsh_reg;
    logic [SQ_BITS-1:0]      quo_reg;
    logic [5:0]              dcnt_reg;

    logic [SQ_BITS-1:0]      sx_reg;
    logic [SQ_BITS-1:0]      sres_reg;
    logic [4:0]              si_reg;
    logic [DIST_BITS-1:0]    dist_reg;
    logic                    close_final_reg;

    logic [KCNT_BITS-1:0]    r_reg;

    logic                    out_valid_reg;
    logic [IDX_BITS-1:0]     out_idx_reg;
    logic [DIST_BITS-1:0]    out_dist_reg;
    logic [RANK_BITS-1:0]    out_rank_reg;
    logic                    out_found_reg;
    logic                    out_last_reg;

    // Combinational helpers
    mul_op_t                 op;
    logic signed [31:0]      opa;
    logic signed [31:0]      opb;
    logic signed [63:0]      prod;
    logic signed [63:0]      cdiff;
    logic [63:0]             nbp_fin;
    logic [127:0]            num_fin;
    logic                    seg_done;
    logic [SQ_BITS-1:0]      seg_val;
    logic [SQ_BITS:0]        dtry;
    logic [SQ_BITS:0]        dsub;
    logic                    dge;
    logic [SQ_BITS-1:0]      quo_next;
    logic [SQ_BITS-1:0]      sbit;
    logic [SQ_BITS-1:0]      ssum;
    logic [SQ_BITS-1:0]      sres_next;
    logic                    out_free;
    logic                    emit;
    logic [IDX_BITS-1:0]     e_idx;
    logic [DIST_BITS-1:0]    e_dist;
    logic [RANK_BITS-1:0]    e_rank;
    logic                    e_found;
    logic                    e_last;
    logic                    e_done;
    logic [KCNT_BITS-1:0]    kk;
    logic [KCNT_BITS-1:0]    lim;
    logic [KCNT_BITS-1:0]    lcnt_new;
    logic [KCNT_BITS-1:0]    lt_cnt;
    logic                    eq_hit;
    logic [KCNT_BITS-1:0]    cnt_ins;
    logic [DIST_BITS-1:0]    nd [MAX_K];
    logic [IDX_BITS-1:0]     ni [MAX_K];

    function automatic logic signed [31:0] pick(
        input logic [3:0] code,
        input logic signed [COORD_BITS:0] ab0, ab1, ab2, ap0, ap1, ap2, bp0, bp1, bp2,
        input logic [SQ_BITS-1:0] c
    );
        logic signed [31:0] v;
        case (code)
            SRC_AB0: v = 32'(ab0);
            SRC_AB1: v = 32'(ab1);
            SRC_AB2: v = 32'(ab2);
            SRC_AP0: v = 32'(ap0);
            SRC_AP1: v = 32'(ap1);
            SRC_AP2: v = 32'(ap2);
            SRC_BP0: v = 32'(bp0);
            SRC_BP1: v = 32'(bp1);
            SRC_BP2: v = 32'(bp2);
            SRC_CLO: v = {1'b0, c[30:0]};
            SRC_CHI: v = {1'b0, c[61:31]};
            default: v = '0;
        endcase
        return v;
    endfunction

    assign q_pop = q_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        op   = mul_op(step_reg);
        opa  = pick(op.src_a, ab_reg[0], ab_reg[1], ab_reg[2], ap_reg[0], ap_reg[1],
                    ap_reg[2], bp_reg[0], bp_reg[1], bp_reg[2], c_reg);
        opb  = pick(op.src_b, ab_reg[0], ab_reg[1], ab_reg[2], ap_reg[0], ap_reg[1],
                    ap_reg[2], bp_reg[0], bp_reg[1], bp_reg[2], c_reg);
        prod = opa * opb;
        cdiff   = t1_reg - mul_reg;
        nbp_fin = nbp_reg + 64'(mul_reg);
        num_fin = num_reg + ({64'd0, mul_reg} << 62);

        // Endpoint or projection choice once norms and dots are in.
        seg_done = 1'b0;
        seg_val  = '0;
        if (state_reg == ST_MUL && phase_reg && step_reg == STEP_ENDPT)
        begin
            if (len2_reg == '0 || dot1_reg < 0)
            begin
                seg_done = 1'b1;
                seg_val  = nap_reg[SQ_BITS-1:0];
            end
            else if (dot2_reg > 0)
            begin
                seg_done = 1'b1;
                seg_val  = nbp_fin[SQ_BITS-1:0];
            end
        end

        dtry     = {rem_reg, nsh_reg[SQ_BITS-1]};
        dsub     = dtry - {1'b0, len2_reg[SQ_BITS-1:0]};
        dge      = dtry >= {1'b0, len2_reg[SQ_BITS-1:0]};
        quo_next = {quo_reg[SQ_BITS-2:0], dge};
        if (state_reg == ST_DIV && dcnt_reg == 6'd1)
        begin
            seg_done = 1'b1;
            seg_val  = quo_next;
        end

        sbit      = SQ_BITS'(1) << {si_reg, 1'b0};
        ssum      = sres_reg + sbit;
        sres_next = (sx_reg >= ssum) ? ((sres_reg >> 1) + sbit) : (sres_reg >> 1);

        kk  = (k_nearest == '0) ? KCNT_BITS'(1)
            : ((k_nearest > KCNT_BITS'(MAX_K)) ? KCNT_BITS'(MAX_K) : k_nearest);
        lim = (mode == MODE_KNN) ? kk : KCNT_BITS'(1);
        lcnt_new = (lim > count_reg) ? count_reg : lim;

        // Sorted insert for the k nearest list.
        lt_cnt = '0;
        eq_hit = 1'b0;
        for (int i = 0; i < MAX_K; i++)
        begin
            if (KCNT_BITS'(i) < count_reg && bd_reg[i] < dist_reg)
                lt_cnt = lt_cnt + 1'b1;
            if (KCNT_BITS'(i) < count_reg && bd_reg[i] == dist_reg)
                eq_hit = 1'b1;
        end
        cnt_ins = (!eq_hit && count_reg < KCNT_BITS'(MAX_K)) ? count_reg + 1'b1 : count_reg;
        for (int i = 0; i < MAX_K; i++)
        begin
            nd[i] = bd_reg[i];
            ni[i] = bi_reg[i];
        end
        if (!eq_hit)
        begin
            for (int i = 1; i < MAX_K; i++)
            begin
                if (KCNT_BITS'(i) > lt_cnt)
                begin
                    nd[i] = bd_reg[i-1];
                    ni[i] = bi_reg[i-1];
                end
            end
        end
        for (int i = 0; i < MAX_K; i++)
        begin
            if (KCNT_BITS'(i) == lt_cnt)
            begin
                nd[i] = dist_reg;
                ni[i] = cur_reg;
            end
        end

        out_free = !out_valid_reg || res_ready;
        emit    = 1'b0;
        e_idx   = '0;
        e_dist  = '0;
        e_rank  = '0;
        e_found = 1'b0;
        e_last  = 1'b0;
        e_done  = 1'b0;
        case (state_reg)
            ST_CLOSE:
            begin
                if (mode == MODE_ALL && has_reg && out_free)
                begin
                    emit    = 1'b1;
                    e_idx   = cur_reg;
                    e_dist  = dist_reg;
                    e_found = 1'b1;
                    e_last  = close_final_reg;
                end
            end
            ST_FINAL:
            begin
                if (!has_reg && mode == MODE_ALL && out_free)
                begin
                    emit   = 1'b1;
                    e_last = 1'b1;
                end
            end
            ST_LIST:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (lcnt_new == '0)
                    begin
                        e_last = 1'b1;
                        e_done = 1'b1;
                    end
                    else
                    begin
                        e_idx   = bi_reg[r_reg[RANK_BITS-1:0]];
                        e_dist  = bd_reg[r_reg[RANK_BITS-1:0]];
                        e_rank  = (mode == MODE_KNN) ? r_reg[RANK_BITS-1:0] : '0;
                        e_found = 1'b1;
                        e_last  = (r_reg + 1'b1) == lcnt_new;
                        e_done  = e_last;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cur_reg   <= '0;
            min_reg   <= ONES62;
            has_reg   <= 1'b0;
            count_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                qp_reg[i]   <= '0;
                prev_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        it_reg    <= q_item;
                        ab_reg[0] <= (COORD_BITS+1)'(q_item.x) - (COORD_BITS+1)'(prev_reg[0]);
                        ab_reg[1] <= (COORD_BITS+1)'(q_item.y) - (COORD_BITS+1)'(prev_reg[1]);
                        ab_reg[2] <= (COORD_BITS+1)'(q_item.z) - (COORD_BITS+1)'(prev_reg[2]);
                        ap_reg[0] <= (COORD_BITS+1)'(qp_reg[0]) - (COORD_BITS+1)'(prev_reg[0]);
                        ap_reg[1] <= (COORD_BITS+1)'(qp_reg[1]) - (COORD_BITS+1)'(prev_reg[1]);
                        ap_reg[2] <= (COORD_BITS+1)'(qp_reg[2]) - (COORD_BITS+1)'(prev_reg[2]);
                        bp_reg[0] <= (COORD_BITS+1)'(qp_reg[0]) - (COORD_BITS+1)'(q_item.x);
                        bp_reg[1] <= (COORD_BITS+1)'(qp_reg[1]) - (COORD_BITS+1)'(q_item.y);
                        bp_reg[2] <= (COORD_BITS+1)'(qp_reg[2]) - (COORD_BITS+1)'(q_item.z);
                        len2_reg  <= '0;
                        dot1_reg  <= '0;
                        dot2_reg  <= '0;
                        nap_reg   <= '0;
                        nbp_reg   <= '0;
                        num_reg   <= '0;
                        step_reg  <= '0;
                        phase_reg <= 1'b0;
                        case (q_item.kind)
                            KIND_QUERY:
                            begin
                                qp_reg[0] <= q_item.x;
                                qp_reg[1] <= q_item.y;
                                qp_reg[2] <= q_item.z;
                                cur_reg   <= '0;
                                min_reg   <= ONES62;
                                has_reg   <= 1'b0;
                                count_reg <= '0;
                            end
                            KIND_OPEN:
                            begin
                                has_reg     <= 1'b0;
                                min_reg     <= ONES62;
                                prev_reg[0] <= q_item.x;
                                prev_reg[1] <= q_item.y;
                                prev_reg[2] <= q_item.z;
                                if (q_item.last_vtx)
                                    state_reg <= ST_FINAL;
                            end
                            KIND_NEXT:
                            begin
                                sx_reg          <= min_reg;
                                sres_reg        <= '0;
                                si_reg          <= 5'd30;
                                close_final_reg <= 1'b0;
                                state_reg       <= has_reg ? ST_SQRT : ST_CLOSE;
                            end
                            default:
                            begin
                                state_reg <= ST_MUL;
                            end
                        endcase
                    end
                end
                ST_MUL:
                begin
                    if (!phase_reg)
                    begin
                        mul_reg   <= prod;
                        phase_reg <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= 1'b0;
                        step_reg  <= step_reg + 1'b1;
                        case (op.dst)
                            DST_LEN:   len2_reg <= len2_reg + 64'(mul_reg);
                            DST_DOT1:  dot1_reg <= dot1_reg + mul_reg;
                            DST_DOT2:  dot2_reg <= dot2_reg + mul_reg;
                            DST_NAP:   nap_reg  <= nap_reg + 64'(mul_reg);
                            DST_NBP:   nbp_reg  <= nbp_fin;
                            DST_T1:    t1_reg   <= mul_reg;
                            DST_CMAG:  c_reg    <= cdiff[63] ? SQ_BITS'(-cdiff) : SQ_BITS'(cdiff);
                            DST_NUM0:  num_reg  <= num_reg + {64'd0, mul_reg};
                            DST_NUM32: num_reg  <= num_reg + ({64'd0, mul_reg} << 32);
                            DST_NUM62: num_reg  <= num_fin;
                            default:   num_reg  <= num_reg;
                        endcase
                        if (step_reg == STEP_LAST)
                        begin
                            // Quotient stays below 2^62, so the top bits seed the remainder.
                            rem_reg   <= num_fin[123:62];
                            nsh_reg   <= num_fin[61:0];
                            quo_reg   <= '0;
                            dcnt_reg  <= 6'(SQ_BITS);
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    rem_reg  <= dge ? dsub[SQ_BITS-1:0] : dtry[SQ_BITS-1:0];
                    nsh_reg  <= nsh_reg << 1;
                    quo_reg  <= quo_next;
                    dcnt_reg <= dcnt_reg - 1'b1;
                end
                ST_SQRT:
                begin
                    if (sx_reg >= ssum)
                        sx_reg <= sx_reg - ssum;
                    sres_reg <= sres_next;
                    si_reg   <= si_reg - 1'b1;
                    if (si_reg == '0)
                    begin
                        dist_reg  <= sres_next[DIST_BITS-1:0];
                        state_reg <= ST_CLOSE;
                    end
                end
                ST_CLOSE:
                begin
                    if (mode != MODE_ALL || out_free)
                    begin
                        if (has_reg && mode == MODE_KNN)
                        begin
                            for (int i = 0; i < MAX_K; i++)
                            begin
                                bd_reg[i] <= nd[i];
                                bi_reg[i] <= ni[i];
                            end
                            count_reg <= cnt_ins;
                        end
                        else if (has_reg && mode != MODE_ALL &&
                                 (count_reg == '0 || dist_reg < bd_reg[0]))
                        begin
                            bd_reg[0] <= dist_reg;
                            bi_reg[0] <= cur_reg;
                            count_reg <= KCNT_BITS'(1);
                        end
                        if (close_final_reg)
                        begin
                            if (mode == MODE_ALL)
                            begin
                                cur_reg   <= '0;
                                min_reg   <= ONES62;
                                has_reg   <= 1'b0;
                                count_reg <= '0;
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                state_reg <= ST_LIST;
                            end
                        end
                        else
                        begin
                            cur_reg     <= cur_reg + 1'b1;
                            has_reg     <= 1'b0;
                            min_reg     <= ONES62;
                            prev_reg[0] <= it_reg.x;
                            prev_reg[1] <= it_reg.y;
                            prev_reg[2] <= it_reg.z;
                            state_reg   <= it_reg.last_vtx ? ST_FINAL : ST_IDLE;
                        end
                    end
                end
                ST_FINAL:
                begin
                    if (has_reg)
                    begin
                        sx_reg          <= min_reg;
                        sres_reg        <= '0;
                        si_reg          <= 5'd30;
                        close_final_reg <= 1'b1;
                        state_reg       <= ST_SQRT;
                    end
                    else if (mode == MODE_ALL)
                    begin
                        if (out_free)
                        begin
                            cur_reg   <= '0;
                            min_reg   <= ONES62;
                            count_reg <= '0;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_LIST;
                    end
                end
                ST_LIST:
                begin
                    if (emit && e_done)
                    begin
                        cur_reg   <= '0;
                        min_reg   <= ONES62;
                        has_reg   <= 1'b0;
                        count_reg <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (seg_done)
            begin
                if (seg_val < min_reg)
                    min_reg <= seg_val;
                has_reg     <= 1'b1;
                prev_reg[0] <= it_reg.x;
                prev_reg[1] <= it_reg.y;
                prev_reg[2] <= it_reg.z;
                state_reg   <= it_reg.last_vtx ? ST_FINAL : ST_IDLE;
            end
        end
    end

    // Hold the rank counter for the result burst.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg <= '0;
        end
        else if (state_reg != ST_LIST)
        begin
            r_reg <= '0;
        end
        else if (emit)
        begin
            r_reg <= r_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (res_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_idx_reg   <= e_idx;
            out_dist_reg  <= e_dist;
            out_rank_reg  <= e_rank;
            out_found_reg <= e_found;
            out_last_reg  <= e_last;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_index = out_idx_reg;
    assign res_dist  = out_dist_reg;
    assign res_rank  = out_rank_reg;
    assign res_found = out_found_reg;
    assign res_last  = out_last_reg;

endmodule

// ----- rtl/nearest_polyline_distance_top.sv -----
// A segment vertex runs the schedule of the shared 32x32 multiplier: on an endpoint it stops
// once norms and dots are in, on a projection it goes on through the cross terms and the
// one-bit-a-cycle divider. Closing a polyline adds the square root; results then
// leave one a cycle while result_ready is high. The back end pops an item only when idle.
// Reset is asynchronous: stream state clears, mode resets to 0 and k_nearest to 5.
module nearest_polyline_distance_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          cmd,
    input  npd_pkg::coord_t               coord_x,
    input  npd_pkg::coord_t               coord_y,
    input  npd_pkg::coord_t               coord_z,
    input  logic                          starts_polyline,
    input  logic                          final_vertex,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [npd_pkg::IDX_BITS-1:0]  polyline_index,
    output logic [npd_pkg::DIST_BITS-1:0] distance,
    output logic [npd_pkg::RANK_BITS-1:0] rank,
    output logic                          found,
    output logic                          last_result,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [npd_pkg::KCNT_BITS-1:0] cfg_data
);
    import npd_pkg::*;

    logic [1:0]           mode_reg;
    logic [KCNT_BITS-1:0] k_reg;
    logic                 q_space;
    logic                 push;
    item_t                push_item;
    logic                 pop;
    logic                 pop_valid;
    item_t                pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NEAREST;
            k_reg    <= KCNT_BITS'(5);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE: mode_reg <= cfg_data[1:0];
                CFG_K:    k_reg    <= cfg_data;
                default:  k_reg    <= k_reg;
            endcase
        end
    end

    npd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .cmd             (cmd),
        .coord_x         (coord_x),
        .coord_y         (coord_y),
        .coord_z         (coord_z),
        .starts_polyline (starts_polyline),
        .final_vertex    (final_vertex),
        .q_space         (q_space),
        .push            (push),
        .push_item       (push_item)
    );

    npd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .space     (q_space),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item)
    );

    npd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_item    (pop_item),
        .q_pop     (pop),
        .mode      (mode_reg),
        .k_nearest (k_reg),
        .res_valid (result_valid),
        .res_ready (result_ready),
        .res_index (polyline_index),
        .res_dist  (distance),
        .res_rank  (rank),
        .res_found (found),
        .res_last  (last_result)
    );

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> last_result)
        else $error("empty result not marked last");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> distance == '0 && polyline_index == '0 && rank == '0)
        else $error("empty result carries data");

    a_rank_knn_only: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && rank != '0 |-> mode_reg == MODE_KNN)
        else $error("nonzero rank outside k nearest mode");

endmodule
